### rtl/slr_pkg.sv
package slr_pkg;

    localparam int MUL_W     = 17;
    localparam int DIV_NW    = 40;
    localparam int DIV_DW    = 32;
    localparam int SQ_W      = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [SQ_W-1:0] SQRT_BIT0 = 32'h4000_0000;
    localparam logic [DIV_DW-1:0] HUNDRED = 32'd100;

    localparam logic [1:0] OP_MOVE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_BRAKE = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] MODE_STOP  = 2'd0;
    localparam logic [1:0] MODE_ACCEL = 2'd1;
    localparam logic [1:0] MODE_DECEL = 2'd2;
    localparam logic [1:0] MODE_RUN   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SQRT_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUMMY_PERIOD      = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] step_count_req;
        logic [15:0]        accel_rate;
        logic [15:0]        decel_rate;
        logic [15:0]        top_speed;
        logic               limit_switch;
    } cmd_t;

    typedef struct packed {
        logic               step_pulse;
        logic               direction_out;
        logic [15:0]        timer_period;
        logic               timer_running;
        logic [1:0]         ramp_state;
        logic signed [15:0] position_out;
        logic               homed;
        logic               bad_command;
    } res_t;

endpackage

### rtl/slr_serial_mul.sv
module slr_serial_mul
    import slr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic                 done,
    output logic [2*MUL_W-1:0]   product
);

    localparam int CNT_W = $clog2(MUL_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [2*MUL_W-1:0]   mcand_reg;
    logic [MUL_W-1:0]     mplier_reg;
    logic [2*MUL_W-1:0]   acc_reg;

    // one multiplier bit per cycle, shift and add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                mcand_reg  <= (2*MUL_W)'(a);
                mplier_reg <= b;
                acc_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### rtl/slr_serial_div.sv
module slr_serial_div
    import slr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_NW-1:0]   dividend,
    input  logic [DIV_DW-1:0]   divisor,
    output logic                done,
    output logic [DIV_NW-1:0]   quotient,
    output logic [DIV_DW-1:0]   remainder
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIV_NW-1:0]   q_reg;
    logic [DIV_DW-1:0]   r_reg;
    logic [DIV_DW-1:0]   d_reg;
    logic [DIV_DW:0]     rem_sh;
    logic [DIV_DW:0]     diff;

    assign rem_sh = {r_reg, q_reg[DIV_NW-1]};
    assign diff   = rem_sh - {1'b0, d_reg};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end
            else if (busy_reg)
            begin
                if (!diff[DIV_DW])
                begin
                    r_reg <= diff[DIV_DW-1:0];
                    q_reg <= {q_reg[DIV_NW-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= rem_sh[DIV_DW-1:0];
                    q_reg <= {q_reg[DIV_NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

### rtl/slr_isqrt.sv
module slr_isqrt
    import slr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   x,
    output logic              done,
    output logic [MUL_W-1:0]  root
);

    logic              busy_reg;
    logic              done_reg;
    logic [3:0]        cnt_reg;
    logic [SQ_W-1:0]   root_reg;
    logic [SQ_W-1:0]   bit_reg;
    logic [SQ_W-1:0]   left_reg;
    logic [SQ_W:0]     trial;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};

    // one result bit per cycle, sixteen passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            root_reg <= '0;
            bit_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                root_reg <= '0;
                bit_reg  <= SQRT_BIT0;
                left_reg <= x;
            end
            else if (busy_reg)
            begin
                if (trial <= {1'b0, left_reg})
                begin
                    left_reg <= left_reg - trial[SQ_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // round up when the remainder exceeds the root
    assign done = done_reg;
    assign root = {1'b0, root_reg[MUL_W-2:0]} + MUL_W'(root_reg < left_reg);

endmodule

### rtl/stepper_linear_speed_ramp.sv
// one transaction in flight at a time; the result register frees the input side
// next transaction taken in the cycle after each result is registered
// timer tick: in accel or decel it waits on the serial divider
// move: waits on serial multiplies, divides and the root; a rejected move stops after the check
// brake, zero- and single-step moves, no-op: handled without the arithmetic units
// reset: asynchronous, active low; motor stopped, position zero, registers at defaults
module stepper_linear_speed_ramp
    import slr_pkg::*;
#(
    parameter int DELAY_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cmd_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output res_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int D = DELAY_BITS;
    localparam logic [DIV_NW-1:0] DMAX = (DIV_NW'(1) << DELAY_BITS) - DIV_NW'(1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DEC  = 5'd1;
    localparam logic [4:0] S_SPM  = 5'd2;
    localparam logic [4:0] S_SPD  = 5'd3;
    localparam logic [4:0] S_CHK  = 5'd4;
    localparam logic [4:0] S_FLD  = 5'd5;
    localparam logic [4:0] S_ASD  = 5'd6;
    localparam logic [4:0] S_SQR  = 5'd7;
    localparam logic [4:0] S_FDM  = 5'd8;
    localparam logic [4:0] S_FDD  = 5'd9;
    localparam logic [4:0] S_SSM  = 5'd10;
    localparam logic [4:0] S_SSD  = 5'd11;
    localparam logic [4:0] S_ALM  = 5'd12;
    localparam logic [4:0] S_ALD  = 5'd13;
    localparam logic [4:0] S_BRN  = 5'd14;
    localparam logic [4:0] S_DVM  = 5'd15;
    localparam logic [4:0] S_DVD  = 5'd16;
    localparam logic [4:0] S_COM  = 5'd17;
    localparam logic [4:0] S_THM  = 5'd18;
    localparam logic [4:0] S_TMD  = 5'd19;
    localparam logic [4:0] S_TDV  = 5'd20;
    localparam logic [4:0] S_TUP  = 5'd21;
    localparam logic [4:0] S_OUT  = 5'd22;

    function automatic logic [D-1:0] sat_d(input logic [DIV_NW-1:0] v);
        if (v > DMAX)
        begin
            sat_d = DMAX[D-1:0];
        end
        else
        begin
            sat_d = v[D-1:0];
        end
    endfunction

    // configuration
    logic [31:0] mds_reg;
    logic [15:0] fds_reg;
    logic [31:0] ass_reg;
    logic [15:0] sls_reg;
    logic [15:0] dum_reg;

    // ramp state
    logic [4:0]          state_reg;
    logic [1:0]          mode_reg;
    logic                dir_reg;
    logic [D-1:0]        delay_now_reg;
    logic [15:0]         decel_begin_reg;
    logic [15:0]         decel_steps_reg;
    logic [D-1:0]        floor_reg;
    logic [15:0]         ri_reg;
    logic [D-1:0]        dac_reg;
    logic [15:0]         sd_reg;
    logic [31:0]         rc_reg;
    logic [15:0]         pos_reg;
    logic                ticking_reg;

    // transaction working registers
    cmd_t                cmd_reg;
    logic                launched_reg;
    logic [31:0]         spdiv_reg;
    logic [D-1:0]        floor_t_reg;
    logic [D-1:0]        first_t_reg;
    logic [15:0]         smax_reg;
    logic [16:0]         alim_reg;
    logic [17:0]         dval_reg;
    logic [D-1:0]        nd_reg;
    logic                pulse_reg;
    logic [15:0]         period_reg;
    logic                homed_reg;
    logic                bad_reg;
    logic                out_valid_reg;
    res_t                out_data_reg;

    // units
    logic                mul_go, div_go, sq_go;
    logic                mul_start, div_start, sq_start;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic                mul_done, div_done, sq_done, unit_done;
    logic [2*MUL_W-1:0]  mul_p;
    logic [DIV_NW-1:0]   div_n, div_q;
    logic [DIV_DW-1:0]   div_d, div_r;
    logic [MUL_W-1:0]    sq_root;

    // move decode
    logic                neg;
    logic [16:0]         mag;
    logic [17:0]         dv;

    // tick recurrence
    logic [DIV_NW-1:0]   num_s, num_mag;
    logic                num_neg;
    logic [17:0]         den_s, den_mag;
    logic                den_neg;
    logic [DIV_NW:0]     nd_full;
    logic [D-1:0]        nd_sat;
    logic [15:0]         period_sat;

    assign neg = cmd_reg.step_count_req[15];
    assign mag = neg ? (17'h10000 - {1'b0, cmd_reg.step_count_req})
                     : {1'b0, cmd_reg.step_count_req};
    assign dv  = (dval_reg == 18'd0) ? 18'h3FFFF : dval_reg;

    assign num_s   = (DIV_NW'(delay_now_reg) << 1) + DIV_NW'($signed(rc_reg));
    assign num_neg = num_s[DIV_NW-1];
    assign num_mag = num_neg ? (DIV_NW'(0) - num_s) : num_s;
    assign den_s   = {ri_reg, 2'b01};
    assign den_neg = den_s[17];
    assign den_mag = den_neg ? (18'd0 - den_s) : den_s;
    assign nd_full = (num_neg ^ den_neg)
                   ? ({1'b0, DIV_NW'(delay_now_reg)} + {1'b0, div_q})
                   : ({1'b0, DIV_NW'(delay_now_reg)} - {1'b0, div_q});
    assign nd_sat  = nd_full[DIV_NW] ? '0 : sat_d(nd_full[DIV_NW-1:0]);
    assign period_sat = (DIV_NW'(delay_now_reg) > DIV_NW'(16'hFFFF))
                      ? 16'hFFFF : delay_now_reg[15:0];

    always_comb
    begin
        mul_go = 1'b0;
        div_go = 1'b0;
        sq_go  = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        div_n  = '0;
        div_d  = '0;
        unique case (state_reg)
            S_SPM:
            begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(sls_reg);
                mul_b  = MUL_W'(cmd_reg.accel_rate);
            end
            S_SPD, S_FDD:
            begin
                div_go = 1'b1;
                div_n  = DIV_NW'(mul_p);
                div_d  = HUNDRED;
            end
            S_FLD:
            begin
                div_go = 1'b1;
                div_n  = DIV_NW'(mds_reg);
                div_d  = DIV_DW'(cmd_reg.top_speed);
            end
            S_ASD:
            begin
                div_go = 1'b1;
                div_n  = DIV_NW'(ass_reg);
                div_d  = DIV_DW'(cmd_reg.accel_rate);
            end
            S_SQR:
            begin
                sq_go = 1'b1;
            end
            S_FDM:
            begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(fds_reg);
                mul_b  = sq_root;
            end
            S_SSM:
            begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(cmd_reg.top_speed);
                mul_b  = MUL_W'(cmd_reg.top_speed);
            end
            S_SSD:
            begin
                div_go = 1'b1;
                div_n  = DIV_NW'(mul_p);
                div_d  = spdiv_reg;
            end
            S_ALM:
            begin
                mul_go = 1'b1;
                mul_a  = mag;
                mul_b  = MUL_W'(cmd_reg.decel_rate);
            end
            S_ALD:
            begin
                div_go = 1'b1;
                div_n  = DIV_NW'(mul_p);
                div_d  = DIV_DW'(cmd_reg.accel_rate) + DIV_DW'(cmd_reg.decel_rate);
            end
            S_DVM:
            begin
                mul_go = 1'b1;
                mul_a  = MUL_W'(smax_reg);
                mul_b  = MUL_W'(cmd_reg.accel_rate);
            end
            S_DVD:
            begin
                div_go = 1'b1;
                div_n  = DIV_NW'(mul_p);
                div_d  = DIV_DW'(cmd_reg.decel_rate);
            end
            S_TDV:
            begin
                div_go = 1'b1;
                div_n  = num_mag;
                div_d  = DIV_DW'(den_mag);
            end
            default:
            begin
            end
        endcase
    end

    assign mul_start = mul_go & ~launched_reg;
    assign div_start = div_go & ~launched_reg;
    assign sq_start  = sq_go & ~launched_reg;
    assign unit_done = mul_done | div_done | sq_done;

    slr_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    slr_serial_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    slr_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (div_q[SQ_W-1:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mds_reg <= 32'd392699;
            fds_reg <= 16'd845;
            ass_reg <= 32'd628318530;
            sls_reg <= 16'd628;
            dum_reg <= 16'd125;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_DELAY_SCALE:   mds_reg <= cfg_data;
                REG_FIRST_DELAY_SCALE: fds_reg <= cfg_data[15:0];
                REG_ACCEL_SQRT_SCALE:  ass_reg <= cfg_data;
                REG_SPEED_LIMIT_SCALE: sls_reg <= cfg_data[15:0];
                REG_DUMMY_PERIOD:      dum_reg <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= MODE_STOP;
            dir_reg         <= 1'b0;
            delay_now_reg   <= '0;
            decel_begin_reg <= '0;
            decel_steps_reg <= '0;
            floor_reg       <= '0;
            ri_reg          <= '0;
            dac_reg         <= '0;
            sd_reg          <= '0;
            rc_reg          <= '0;
            pos_reg         <= '0;
            ticking_reg     <= 1'b0;
            cmd_reg         <= '0;
            launched_reg    <= 1'b0;
            spdiv_reg       <= '0;
            floor_t_reg     <= '0;
            first_t_reg     <= '0;
            smax_reg        <= '0;
            alim_reg        <= '0;
            dval_reg        <= '0;
            nd_reg          <= '0;
            pulse_reg       <= 1'b0;
            period_reg      <= '0;
            homed_reg       <= 1'b0;
            bad_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mul_start || div_start || sq_start)
            begin
                launched_reg <= 1'b1;
            end
            else if (unit_done)
            begin
                launched_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg    <= in_data;
                        pulse_reg  <= 1'b0;
                        period_reg <= '0;
                        homed_reg  <= 1'b0;
                        bad_reg    <= 1'b0;
                        state_reg  <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    unique case (cmd_reg.operation)
                        OP_MOVE:
                        begin
                            if (mag == 17'd0)
                            begin
                                dir_reg   <= neg;
                                state_reg <= S_OUT;
                            end
                            else if (mag == 17'd1)
                            begin
                                dir_reg       <= neg;
                                ri_reg        <= 16'hFFFF;
                                mode_reg      <= MODE_DECEL;
                                delay_now_reg <= D'(dum_reg);
                                period_reg    <= dum_reg;
                                ticking_reg   <= 1'b1;
                                state_reg     <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_SPM;
                            end
                        end
                        OP_TICK:
                        begin
                            state_reg <= S_THM;
                        end
                        OP_BRAKE:
                        begin
                            ticking_reg     <= 1'b0;
                            mode_reg        <= MODE_STOP;
                            dir_reg         <= 1'b0;
                            delay_now_reg   <= '0;
                            decel_begin_reg <= '0;
                            decel_steps_reg <= '0;
                            floor_reg       <= '0;
                            ri_reg          <= '0;
                            dac_reg         <= '0;
                            sd_reg          <= '0;
                            rc_reg          <= '0;
                            state_reg       <= S_OUT;
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_SPM:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_SPD;
                    end
                end
                S_SPD:
                begin
                    if (div_done)
                    begin
                        spdiv_reg <= div_q[31:0];
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (cmd_reg.top_speed == 16'd0 || spdiv_reg == 32'd0)
                    begin
                        bad_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_FLD;
                    end
                end
                S_FLD:
                begin
                    if (div_done)
                    begin
                        floor_t_reg <= sat_d(div_q);
                        state_reg   <= S_ASD;
                    end
                end
                S_ASD:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SQR;
                    end
                end
                S_SQR:
                begin
                    if (sq_done)
                    begin
                        state_reg <= S_FDM;
                    end
                end
                S_FDM:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_FDD;
                    end
                end
                S_FDD:
                begin
                    if (div_done)
                    begin
                        first_t_reg <= sat_d(div_q);
                        state_reg   <= S_SSM;
                    end
                end
                S_SSM:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_SSD;
                    end
                end
                S_SSD:
                begin
                    if (div_done)
                    begin
                        if (div_q > DIV_NW'(16'hFFFF))
                        begin
                            smax_reg <= 16'hFFFF;
                        end
                        else if (div_q == '0)
                        begin
                            smax_reg <= 16'd1;
                        end
                        else
                        begin
                            smax_reg <= div_q[15:0];
                        end
                        state_reg <= S_ALM;
                    end
                end
                S_ALM:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_ALD;
                    end
                end
                S_ALD:
                begin
                    if (div_done)
                    begin
                        alim_reg  <= (div_q == '0) ? 17'd1 : div_q[16:0];
                        state_reg <= S_BRN;
                    end
                end
                S_BRN:
                begin
                    if (alim_reg <= {1'b0, smax_reg} || cmd_reg.decel_rate == 16'd0)
                    begin
                        dval_reg  <= {1'b0, alim_reg} - {1'b0, mag};
                        state_reg <= S_COM;
                    end
                    else
                    begin
                        state_reg <= S_DVM;
                    end
                end
                S_DVM:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_DVD;
                    end
                end
                S_DVD:
                begin
                    if (div_done)
                    begin
                        if (div_q >= DIV_NW'(32768))
                        begin
                            dval_reg <= 18'h38000;
                        end
                        else
                        begin
                            dval_reg <= 18'd0 - {2'b00, div_q[15:0]};
                        end
                        state_reg <= S_COM;
                    end
                end
                S_COM:
                begin
                    dir_reg         <= neg;
                    decel_steps_reg <= dv[15:0];
                    decel_begin_reg <= mag[15:0] + dv[15:0];
                    floor_reg       <= floor_t_reg;
                    if (first_t_reg <= floor_t_reg)
                    begin
                        delay_now_reg <= floor_t_reg;
                        mode_reg      <= MODE_RUN;
                    end
                    else
                    begin
                        delay_now_reg <= first_t_reg;
                        mode_reg      <= MODE_ACCEL;
                    end
                    ri_reg      <= '0;
                    period_reg  <= dum_reg;
                    ticking_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_THM:
                begin
                    period_reg <= period_sat;
                    if (dir_reg && cmd_reg.limit_switch)
                    begin
                        // homing: brake and zero the position before the tick proper
                        ticking_reg     <= 1'b0;
                        mode_reg        <= MODE_STOP;
                        dir_reg         <= 1'b0;
                        delay_now_reg   <= '0;
                        decel_begin_reg <= '0;
                        decel_steps_reg <= '0;
                        floor_reg       <= '0;
                        ri_reg          <= '0;
                        dac_reg         <= '0;
                        sd_reg          <= '0;
                        rc_reg          <= '0;
                        pos_reg         <= '0;
                        homed_reg       <= 1'b1;
                    end
                    state_reg <= S_TMD;
                end
                S_TMD:
                begin
                    if (mode_reg == MODE_STOP)
                    begin
                        sd_reg        <= '0;
                        rc_reg        <= '0;
                        ticking_reg   <= 1'b0;
                        delay_now_reg <= '0;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        pulse_reg <= 1'b1;
                        pos_reg   <= dir_reg ? (pos_reg - 16'd1) : (pos_reg + 16'd1);
                        sd_reg    <= sd_reg + 16'd1;
                        if (mode_reg == MODE_RUN)
                        begin
                            state_reg <= S_TUP;
                        end
                        else
                        begin
                            ri_reg    <= ri_reg + 16'd1;
                            state_reg <= S_TDV;
                        end
                    end
                end
                S_TDV:
                begin
                    if (div_done)
                    begin
                        nd_reg    <= nd_sat;
                        rc_reg    <= num_neg ? (32'd0 - div_r) : div_r;
                        state_reg <= S_TUP;
                    end
                end
                S_TUP:
                begin
                    state_reg <= S_OUT;
                    unique case (mode_reg)
                        MODE_ACCEL:
                        begin
                            if (sd_reg >= decel_begin_reg)
                            begin
                                ri_reg        <= decel_steps_reg;
                                mode_reg      <= MODE_DECEL;
                                delay_now_reg <= nd_reg;
                            end
                            else if (nd_reg <= floor_reg)
                            begin
                                dac_reg       <= nd_reg;
                                delay_now_reg <= floor_reg;
                                rc_reg        <= '0;
                                mode_reg      <= MODE_RUN;
                            end
                            else
                            begin
                                delay_now_reg <= nd_reg;
                            end
                        end
                        MODE_RUN:
                        begin
                            if (sd_reg >= decel_begin_reg)
                            begin
                                ri_reg        <= decel_steps_reg;
                                delay_now_reg <= dac_reg;
                                mode_reg      <= MODE_DECEL;
                            end
                            else
                            begin
                                delay_now_reg <= floor_reg;
                            end
                        end
                        MODE_DECEL:
                        begin
                            delay_now_reg <= nd_reg;
                            if (!ri_reg[15])
                            begin
                                mode_reg <= MODE_STOP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_data_reg.step_pulse    <= pulse_reg;
                        out_data_reg.direction_out <= dir_reg;
                        out_data_reg.timer_period  <= period_reg;
                        out_data_reg.timer_running <= ticking_reg;
                        out_data_reg.ramp_state    <= mode_reg;
                        out_data_reg.position_out  <= pos_reg;
                        out_data_reg.homed         <= homed_reg;
                        out_data_reg.bad_command   <= bad_reg;
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
